### rtl/core/tgtp_pkg.sv
`default_nettype none

package tgtp_pkg;

   localparam int COORD_BITS     = 12;
   localparam int RES_BITS       = 13;
   localparam int TILE_BITS      = 8;
   localparam int COLOR_BITS     = 32;
   localparam int STEP_BITS      = 8;
   localparam int DEPTH_BITS     = 6;
   localparam int LAYOUT_BITS    = 30;
   localparam int FIELD_BITS     = 5;
   localparam int CHANNELS       = 3;
   localparam int CHAN_MAX       = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // tile index is built two quotient bits per stage
   localparam int LOCATE_STAGES  = TILE_BITS / 2;
   localparam int SHIFT_BITS     = $clog2(TILE_BITS);
   localparam int DIV_W          = RES_BITS + TILE_BITS - 1;
   localparam int CMP_W          = (COORD_BITS > RES_BITS) ? COORD_BITS : RES_BITS;
   localparam int DIV_COUNT_BITS = $clog2(RES_BITS);
   localparam int INDEX_BITS     = 2 * TILE_BITS;
   localparam int PROD_BITS      = INDEX_BITS + STEP_BITS;

   localparam logic [RES_BITS-1:0]    HRES_RESET    = 13'd1024;
   localparam logic [RES_BITS-1:0]    VRES_RESET    = 13'd768;
   localparam logic [TILE_BITS-1:0]   TILES_RESET   = 8'd1;
   localparam logic [COLOR_BITS-1:0]  FIRST_RESET   = 32'd0;
   localparam logic [STEP_BITS-1:0]   STEP_RESET    = 8'd0;
   localparam logic                   INDEXED_RESET = 1'b1;
   localparam logic [DEPTH_BITS-1:0]  DEPTH_RESET   = 6'd8;
   localparam logic [LAYOUT_BITS-1:0] LAYOUT_RESET  = 30'h10042110;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HRES    = 3'd0,
      CSR_VRES    = 3'd1,
      CSR_TILES   = 3'd2,
      CSR_FIRST   = 3'd3,
      CSR_STEP    = 3'd4,
      CSR_INDEXED = 3'd5,
      CSR_DEPTH   = 3'd6,
      CSR_LAYOUT  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      GEO_LOAD,
      GEO_DIVIDE,
      GEO_SCALE,
      GEO_READY
   } geo_state_type;

   typedef struct packed {
      logic [RES_BITS-1:0] tw;
      logic [RES_BITS-1:0] th;
      logic [RES_BITS-1:0] lim_x;
      logic [RES_BITS-1:0] lim_y;
      logic                grid_ok;
   } geo_type;

   typedef struct packed {
      logic [TILE_BITS-1:0]   tiles;
      logic [COLOR_BITS-1:0]  first;
      logic [STEP_BITS-1:0]   step;
      logic                   indexed;
      logic [DEPTH_BITS-1:0]  depth;
      logic [LAYOUT_BITS-1:0] layout;
   } color_cfg_type;

   typedef struct packed {
      logic [TILE_BITS-1:0] col;
      logic [TILE_BITS-1:0] row;
      logic                 in_grid;
   } tile_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] rem;
      logic                  q;
   } div_step_type;

   function automatic logic [COLOR_BITS-1:0] low_mask(input logic [DEPTH_BITS-1:0] bits);
      logic [COLOR_BITS-1:0] m;
      if (bits >= DEPTH_BITS'(COLOR_BITS)) begin
         m = '1;
      end else begin
         m = (COLOR_BITS'(1) << bits) - COLOR_BITS'(1);
      end
      return m;
   endfunction

   // one restoring step against the divisor shifted up by k
   function automatic div_step_type div_step(input logic [COORD_BITS-1:0] rem,
                                             input logic [RES_BITS-1:0]   dvs,
                                             input logic [SHIFT_BITS-1:0] k);
      logic [DIV_W-1:0] r_ext;
      logic [DIV_W-1:0] d_ext;
      div_step_type     s;
      r_ext = DIV_W'(rem);
      d_ext = DIV_W'(dvs) << k;
      if (r_ext >= d_ext) begin
         s.rem = COORD_BITS'(r_ext - d_ext);
         s.q   = 1'b1;
      end else begin
         s.rem = rem;
         s.q   = 1'b0;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/core/tgtp_req_if.sv
`default_nettype none

interface tgtp_req_if import tgtp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

### rtl/core/tgtp_rsp_if.sv
`default_nettype none

interface tgtp_rsp_if import tgtp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] pixel_color;
   logic                  inside_grid;

   modport source (output valid, output pixel_color, output inside_grid, input ready);
   modport sink   (input valid, input pixel_color, input inside_grid, output ready);
endinterface

`default_nettype wire

### rtl/core/tgtp_csr_if.sv
`default_nettype none

interface tgtp_csr_if import tgtp_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/tgtp_geometry.sv
`default_nettype none

module tgtp_geometry import tgtp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   tgtp_csr_if.sink      csr_chan,
   output geo_type       geo,
   output color_cfg_type cfg,
   output logic          geo_ready
);

   logic [RES_BITS-1:0]    hres_ff;
   logic [RES_BITS-1:0]    vres_ff;
   logic [TILE_BITS-1:0]   tiles_ff;
   logic [COLOR_BITS-1:0]  first_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic                   indexed_ff;
   logic [DEPTH_BITS-1:0]  depth_ff;
   logic [LAYOUT_BITS-1:0] layout_ff;

   geo_state_type          state_ff;
   geo_state_type          state_in;
   logic                   load_en;
   logic                   step_en;
   logic                   scale_en;

   logic                   csr_beat;
   logic                   geo_write;
   csr_index_type          csr_index;

   logic [RES_BITS-1:0]       dq_h_ff, dq_v_ff, dq_h_in, dq_v_in;
   logic [TILE_BITS-1:0]      rem_h_ff, rem_v_ff, rem_h_in, rem_v_in;
   logic [TILE_BITS:0]        trial_h, trial_v;
   logic [DIV_COUNT_BITS-1:0] cnt_ff;
   logic [RES_BITS-1:0]       tw_ff, th_ff, lim_x_ff, lim_y_ff;
   logic [DIV_W:0]            lim_x_full, lim_y_full;

   assign csr_chan.ready = 1'b1;
   assign csr_beat       = csr_chan.valid;
   assign csr_index      = csr_index_type'(csr_chan.index);
   assign geo_write      = csr_beat && (csr_index inside {CSR_HRES, CSR_VRES, CSR_TILES});

   always_ff @(posedge clock) begin
      if (reset) begin
         hres_ff    <= HRES_RESET;
         vres_ff    <= VRES_RESET;
         tiles_ff   <= TILES_RESET;
         first_ff   <= FIRST_RESET;
         step_ff    <= STEP_RESET;
         indexed_ff <= INDEXED_RESET;
         depth_ff   <= DEPTH_RESET;
         layout_ff  <= LAYOUT_RESET;
      end else if (csr_beat) begin
         case (csr_index)
            CSR_HRES:    hres_ff    <= csr_chan.data[RES_BITS-1:0];
            CSR_VRES:    vres_ff    <= csr_chan.data[RES_BITS-1:0];
            CSR_TILES:   tiles_ff   <= csr_chan.data[TILE_BITS-1:0];
            CSR_FIRST:   first_ff   <= csr_chan.data[COLOR_BITS-1:0];
            CSR_STEP:    step_ff    <= csr_chan.data[STEP_BITS-1:0];
            CSR_INDEXED: indexed_ff <= csr_chan.data[0];
            CSR_DEPTH:   depth_ff   <= csr_chan.data[DEPTH_BITS-1:0];
            CSR_LAYOUT:  layout_ff  <= csr_chan.data[LAYOUT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         GEO_LOAD:   state_in = GEO_DIVIDE;
         GEO_DIVIDE: begin
            if (cnt_ff == DIV_COUNT_BITS'(RES_BITS - 1)) begin
               state_in = GEO_SCALE;
            end
         end
         GEO_SCALE:  state_in = GEO_READY;
         GEO_READY:  state_in = GEO_READY;
         default:    state_in = GEO_LOAD;
      endcase
      // a new resolution or tile count restarts the division
      if (geo_write) begin
         state_in = GEO_LOAD;
      end
   end

   // outputs of the sequencer
   always_comb begin
      load_en   = 1'b0;
      step_en   = 1'b0;
      scale_en  = 1'b0;
      geo_ready = 1'b0;
      case (state_ff)
         GEO_LOAD:   load_en   = 1'b1;
         GEO_DIVIDE: step_en   = 1'b1;
         GEO_SCALE:  scale_en  = 1'b1;
         GEO_READY:  geo_ready = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEO_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // width / n and height / n, one quotient bit a cycle
   always_comb begin
      trial_h  = {rem_h_ff, dq_h_ff[RES_BITS-1]};
      trial_v  = {rem_v_ff, dq_v_ff[RES_BITS-1]};
      rem_h_in = trial_h[TILE_BITS-1:0];
      rem_v_in = trial_v[TILE_BITS-1:0];
      dq_h_in  = {dq_h_ff[RES_BITS-2:0], 1'b0};
      dq_v_in  = {dq_v_ff[RES_BITS-2:0], 1'b0};
      if (trial_h >= {1'b0, tiles_ff}) begin
         rem_h_in   = TILE_BITS'(trial_h - {1'b0, tiles_ff});
         dq_h_in[0] = 1'b1;
      end
      if (trial_v >= {1'b0, tiles_ff}) begin
         rem_v_in   = TILE_BITS'(trial_v - {1'b0, tiles_ff});
         dq_v_in[0] = 1'b1;
      end
      lim_x_full = (DIV_W + 1)'(dq_h_ff) * (DIV_W + 1)'(tiles_ff);
      lim_y_full = (DIV_W + 1)'(dq_v_ff) * (DIV_W + 1)'(tiles_ff);
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         dq_h_ff  <= hres_ff;
         dq_v_ff  <= vres_ff;
         rem_h_ff <= '0;
         rem_v_ff <= '0;
         cnt_ff   <= '0;
      end else if (step_en) begin
         dq_h_ff  <= dq_h_in;
         dq_v_ff  <= dq_v_in;
         rem_h_ff <= rem_h_in;
         rem_v_ff <= rem_v_in;
         cnt_ff   <= cnt_ff + DIV_COUNT_BITS'(1);
      end
      if (scale_en) begin
         tw_ff    <= dq_h_ff;
         th_ff    <= dq_v_ff;
         lim_x_ff <= lim_x_full[RES_BITS-1:0];
         lim_y_ff <= lim_y_full[RES_BITS-1:0];
      end
   end

   assign geo.tw      = tw_ff;
   assign geo.th      = th_ff;
   assign geo.lim_x   = lim_x_ff;
   assign geo.lim_y   = lim_y_ff;
   assign geo.grid_ok = (tiles_ff != '0) && (tw_ff != '0) && (th_ff != '0);

   assign cfg.tiles   = tiles_ff;
   assign cfg.first   = first_ff;
   assign cfg.step    = step_ff;
   assign cfg.indexed = indexed_ff;
   assign cfg.depth   = depth_ff;
   assign cfg.layout  = layout_ff;

endmodule

`default_nettype wire

### rtl/core/tgtp_locate.sv
`default_nettype none

module tgtp_locate import tgtp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] pixel_x,
   input  logic [COORD_BITS-1:0] pixel_y,
   input  geo_type               geo,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tile_type              tile
);

   logic                  valid_ff  [LOCATE_STAGES];
   logic [COORD_BITS-1:0] rem_x_ff  [LOCATE_STAGES];
   logic [COORD_BITS-1:0] rem_y_ff  [LOCATE_STAGES];
   logic [TILE_BITS-1:0]  col_ff    [LOCATE_STAGES];
   logic [TILE_BITS-1:0]  row_ff    [LOCATE_STAGES];
   logic                  inside_ff [LOCATE_STAGES];
   logic [LOCATE_STAGES:0] en;

   assign en[LOCATE_STAGES] = out_ready;

   for (genvar s = 0; s < LOCATE_STAGES; s++) begin : g_stage
      logic [COORD_BITS-1:0] rx_src, ry_src;
      logic [TILE_BITS-1:0]  c_src, r_src;
      logic                  in_src, v_src;
      div_step_type          sx_hi, sx_lo, sy_hi, sy_lo;

      if (s == 0) begin : g_first
         assign rx_src = pixel_x;
         assign ry_src = pixel_y;
         assign c_src  = '0;
         assign r_src  = '0;
         assign v_src  = in_valid;
         // whole tiles only: the remainder strips fall outside
         assign in_src = geo.grid_ok
                      && (CMP_W'(pixel_x) < CMP_W'(geo.lim_x))
                      && (CMP_W'(pixel_y) < CMP_W'(geo.lim_y));
      end else begin : g_next
         assign rx_src = rem_x_ff[s-1];
         assign ry_src = rem_y_ff[s-1];
         assign c_src  = col_ff[s-1];
         assign r_src  = row_ff[s-1];
         assign v_src  = valid_ff[s-1];
         assign in_src = inside_ff[s-1];
      end

      always_comb begin
         sx_hi = div_step(rx_src,    geo.tw, SHIFT_BITS'(TILE_BITS - 1 - 2 * s));
         sx_lo = div_step(sx_hi.rem, geo.tw, SHIFT_BITS'(TILE_BITS - 2 - 2 * s));
         sy_hi = div_step(ry_src,    geo.th, SHIFT_BITS'(TILE_BITS - 1 - 2 * s));
         sy_lo = div_step(sy_hi.rem, geo.th, SHIFT_BITS'(TILE_BITS - 2 - 2 * s));
      end

      assign en[s] = !valid_ff[s] || en[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en[s]) begin
            valid_ff[s] <= v_src;
         end
         if (en[s]) begin
            rem_x_ff[s]  <= sx_lo.rem;
            rem_y_ff[s]  <= sy_lo.rem;
            col_ff[s]    <= {c_src[TILE_BITS-3:0], sx_hi.q, sx_lo.q};
            row_ff[s]    <= {r_src[TILE_BITS-3:0], sy_hi.q, sy_lo.q};
            inside_ff[s] <= in_src;
         end
      end
   end

   assign in_ready     = en[0];
   assign out_valid    = valid_ff[LOCATE_STAGES-1];
   assign tile.col     = col_ff[LOCATE_STAGES-1];
   assign tile.row     = row_ff[LOCATE_STAGES-1];
   assign tile.in_grid = inside_ff[LOCATE_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/tgtp_color.sv
`default_nettype none

module tgtp_color import tgtp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tile_type              tile,
   input  color_cfg_type         cfg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [COLOR_BITS-1:0] pixel_color,
   output logic                  inside_grid
);

   logic en1, en2, en3;

   // stage 1: tile index and per-channel deltas
   logic                    v1_ff, inside1_ff;
   logic [INDEX_BITS-1:0]   idx_ff, idx_in;
   logic [CHAN_MAX-1:0]     delta_ff [CHANNELS];
   logic [CHAN_MAX-1:0]     delta_in [CHANNELS];
   logic [INDEX_BITS-1:0]   prod_c, prod_r;
   logic [INDEX_BITS:0]     prod_s;
   logic [TILE_BITS:0]      cr_sum;

   // stage 2: indexed product and advanced channel values
   logic                    v2_ff, inside2_ff;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic [CHAN_MAX-1:0]     chan_ff [CHANNELS];
   logic [CHAN_MAX-1:0]     chan_in [CHANNELS];
   logic [FIELD_BITS-1:0]   pos      [CHANNELS];
   logic [FIELD_BITS-1:0]   size_raw [CHANNELS];
   logic [FIELD_BITS-1:0]   size     [CHANNELS];
   logic [CHAN_MAX-1:0]     cmask    [CHANNELS];

   // stage 3: packing and byte truncation
   logic                    v3_ff, inside3_ff;
   logic [COLOR_BITS-1:0]   color_ff, color_in;
   logic [COLOR_BITS-1:0]   indexed_color, direct_color;
   logic [DEPTH_BITS-1:0]   depth, depth_round;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      idx_in      = INDEX_BITS'(INDEX_BITS'(tile.row) * INDEX_BITS'(cfg.tiles))
                  + INDEX_BITS'(tile.col);
      cr_sum      = (TILE_BITS + 1)'(tile.col) + (TILE_BITS + 1)'(tile.row);
      prod_c      = INDEX_BITS'(tile.col) * INDEX_BITS'(cfg.step);
      prod_r      = INDEX_BITS'(tile.row) * INDEX_BITS'(cfg.step);
      prod_s      = (INDEX_BITS + 1)'(cr_sum) * (INDEX_BITS + 1)'(cfg.step);
      // channel masks are at most eight bits, so only the low byte of a delta counts
      delta_in[0] = prod_c[CHAN_MAX-1:0];
      delta_in[1] = prod_r[CHAN_MAX-1:0];
      delta_in[2] = prod_s[CHAN_MAX-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
      if (en1) begin
         inside1_ff <= tile.in_grid;
         idx_ff     <= idx_in;
         for (int c = 0; c < CHANNELS; c++) begin
            delta_ff[c] <= delta_in[c];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         pos[c]      = cfg.layout[2 * c * FIELD_BITS +: FIELD_BITS];
         size_raw[c] = cfg.layout[(2 * c + 1) * FIELD_BITS +: FIELD_BITS];
         size[c]     = (size_raw[c] > FIELD_BITS'(CHAN_MAX)) ? FIELD_BITS'(CHAN_MAX)
                                                             : size_raw[c];
         cmask[c]    = CHAN_MAX'(low_mask(DEPTH_BITS'(size[c])));
         chan_in[c]  = ((CHAN_MAX'(cfg.first >> pos[c]) & cmask[c]) + delta_ff[c])
                     & cmask[c];
      end
      prod_in = PROD_BITS'(idx_ff) * PROD_BITS'(cfg.step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         inside2_ff <= inside1_ff;
         prod_ff    <= prod_in;
         for (int c = 0; c < CHANNELS; c++) begin
            chan_ff[c] <= chan_in[c];
         end
      end
   end

   always_comb begin
      depth = (cfg.depth > DEPTH_BITS'(COLOR_BITS)) ? DEPTH_BITS'(COLOR_BITS) : cfg.depth;
      // whole bytes: round the depth up to a multiple of eight
      depth_round   = (depth + DEPTH_BITS'(7)) & ~DEPTH_BITS'(7);
      indexed_color = (cfg.first + COLOR_BITS'(prod_ff)) & low_mask(depth);
      direct_color  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         direct_color = direct_color | (COLOR_BITS'(chan_ff[c]) << pos[c]);
      end
      if (!inside2_ff) begin
         color_in = '0;
      end else if (cfg.indexed) begin
         color_in = indexed_color & low_mask(depth_round);
      end else begin
         color_in = direct_color & low_mask(depth_round);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         inside3_ff <= inside2_ff;
         color_ff   <= color_in;
      end
   end

   assign out_valid   = v3_ff;
   assign pixel_color = color_ff;
   assign inside_grid = inside3_ff;

endmodule

`default_nettype wire

### rtl/core/tile_grid_test_pattern.sv
// Tile grid test pattern generator: one beat on req_chan carries a pixel
// coordinate (pixel_x, pixel_y); one beat on rsp_chan returns its colour and
// whether it lies in a whole tile of the n-by-n grid.
// csr_chan writes the eight set-up registers by index; it is always ready.
// Throughput is one pixel per clock unless rsp_chan stalls or the dividers
// run. From the request beat to the response beat, four stages find the
// tile column and row, two quotient bits per stage, then three stages form
// index, colour and bytes. Tile width and height are found by two
// one-bit-a-cycle dividers that run side by side. After reset, and after
// any write to the resolution or tile count registers, req_chan.ready stays
// low while they run (load, 13 division steps, scale). Other registers take
// effect at once. Reset is synchronous: pipeline valid bits clear and every
// set-up register returns to its default (1024 by 768, one tile, indexed
// mode, 8 bits per pixel). When the receiver holds rsp_chan.ready low, the
// result stays on rsp_chan, empty stages keep filling and up to seven
// pixels are held in flight before req_chan.ready drops; nothing is lost or repeated.
`default_nettype none

module tile_grid_test_pattern import tgtp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tgtp_req_if.sink    req_chan,
   tgtp_rsp_if.source  rsp_chan,
   tgtp_csr_if.sink    csr_chan
);

   geo_type       geo;
   color_cfg_type cfg;
   logic          geo_ready;
   logic          loc_in_valid, loc_in_ready;
   logic          loc_out_valid, loc_out_ready;
   tile_type      tile;

   tgtp_geometry u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .geo       (geo),
      .cfg       (cfg),
      .geo_ready (geo_ready)
   );

   // hold off requests while tile sizes are being recomputed
   assign loc_in_valid   = req_chan.valid && geo_ready;
   assign req_chan.ready = loc_in_ready && geo_ready;

   tgtp_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (loc_in_valid),
      .in_ready  (loc_in_ready),
      .pixel_x   (req_chan.pixel_x),
      .pixel_y   (req_chan.pixel_y),
      .geo       (geo),
      .out_valid (loc_out_valid),
      .out_ready (loc_out_ready),
      .tile      (tile)
   );

   tgtp_color u_color (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (loc_out_valid),
      .in_ready    (loc_out_ready),
      .tile        (tile),
      .cfg         (cfg),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .pixel_color (rsp_chan.pixel_color),
      .inside_grid (rsp_chan.inside_grid)
   );

endmodule

`default_nettype wire
